/* rtl/c2jp_pkg.sv */
// Shared types, constants and the arctangent table of the joint pulse block.
package c2jp_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned GuardBits   = 8;
  localparam int unsigned VecW        = 44;  // CORDIC x/y, Q32.8 plus growth
  localparam int unsigned ThetaW      = 34;  // turns, Q0.32 plus sign and wrap
  localparam int unsigned CfgIdxW     = 32;

  localparam logic [29:0] InvGainQ30  = 30'd652032874;
  localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;

  // atan(2^-i) in turns, Q0.32
  localparam logic [30:0] AtanTurns [32] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
    31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
  };

  typedef enum logic [CfgIdxW-1:0] {
    RegHeightOffset = 32'd0,
    RegAngleZero    = 32'd1,
    RegRadiusZero   = 32'd2,
    RegHeightZero   = 32'd3,
    RegRotaryRes    = 32'd4,
    RegRadialRes    = 32'd5,
    RegVerticalRes  = 32'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotary_pulses;
    logic signed [31:0] radial_pulses;
    logic signed [31:0] vertical_pulses;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] height_offset;
    logic signed [19:0] angle_zero;
    logic signed [31:0] radius_zero;
    logic signed [31:0] height_zero;
    logic [19:0]        rotary_resolution;
    logic [19:0]        radial_resolution;
    logic [19:0]        vertical_resolution;
  } cfg_t;

  typedef struct packed {
    logic signed [VecW-1:0]   cx;
    logic signed [ThetaW-1:0] theta;
    logic signed [31:0]       z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } clip_t;

  function automatic clip_t clip32(input logic signed [63:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.value = v[31:0];
    if (v > 64'sd2147483647) begin
      r.value = 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.value = 32'sh80000000;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/c2jp_cfg.sv */
// Configuration register file of the joint pulse block.
module c2jp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [c2jp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  output c2jp_pkg::cfg_t                    cfg_o
);

  c2jp_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c2jp_pkg::RegHeightOffset: cfg_q.height_offset       <= cfg_data_i;
        c2jp_pkg::RegAngleZero:    cfg_q.angle_zero          <= cfg_data_i[19:0];
        c2jp_pkg::RegRadiusZero:   cfg_q.radius_zero         <= cfg_data_i;
        c2jp_pkg::RegHeightZero:   cfg_q.height_zero         <= cfg_data_i;
        c2jp_pkg::RegRotaryRes:    cfg_q.rotary_resolution   <= cfg_data_i[19:0];
        c2jp_pkg::RegRadialRes:    cfg_q.radial_resolution   <= cfg_data_i[19:0];
        c2jp_pkg::RegVerticalRes:  cfg_q.vertical_resolution <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/c2jp_cordic.sv */
// Pipelined CORDIC in vectoring mode: one iteration per register stage.
module c2jp_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  c2jp_pkg::in_item_t   item_i,
  output logic                 valid_o,
  output c2jp_pkg::vec_t       vec_o
);

  localparam int unsigned N  = c2jp_pkg::CordicSteps;
  localparam int unsigned VW = c2jp_pkg::VecW;
  localparam int unsigned TW = c2jp_pkg::ThetaW;

  logic signed [VW-1:0] x_q     [N+1];
  logic signed [VW-1:0] y_q     [N+1];
  logic signed [TW-1:0] t_q     [N+1];
  logic signed [31:0]   z_q     [N+1];
  logic                 org_q   [N+1];
  logic                 v_q     [N+1];

  logic signed [VW-1:0] xe, ye;

  assign xe = VW'(item_i.target_x);
  assign ye = VW'(item_i.target_y);

  // Entry stage: fold the lower half plane onto the upper one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]   <= item_i.target_z;
      org_q[0] <= (item_i.target_x == '0) && (item_i.target_y == '0);
      if (!item_i.target_y[31]) begin
        x_q[0] <= ye <<< c2jp_pkg::GuardBits;
        y_q[0] <= xe <<< c2jp_pkg::GuardBits;
        t_q[0] <= '0;
      end else begin
        x_q[0] <= (-ye) <<< c2jp_pkg::GuardBits;
        y_q[0] <= (-xe) <<< c2jp_pkg::GuardBits;
        t_q[0] <= item_i.target_x[31] ? -(TW'(64'sd2147483648))
                                      : TW'(64'sd2147483648);
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [TW-1:0] atan_s;
    assign atan_s = TW'(c2jp_pkg::AtanTurns[i % 32]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]   <= z_q[i];
        org_q[i+1] <= org_q[i];
        if (!y_q[i][VW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          t_q[i+1] <= t_q[i] + atan_s;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          t_q[i+1] <= t_q[i] - atan_s;
        end
      end
    end
  end

  assign valid_o     = v_q[N];
  assign vec_o.cx    = x_q[N];
  assign vec_o.theta = org_q[N] ? '0 : t_q[N];
  assign vec_o.z     = z_q[N];

endmodule

/* rtl/c2jp_scale.sv */
// Gain correction, zero offsets, resolution scaling and saturation.
module c2jp_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  c2jp_pkg::vec_t       vec_i,
  input  c2jp_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output c2jp_pkg::out_item_t  item_o
);

  localparam int unsigned TW = c2jp_pkg::ThetaW;

  logic [4:0] v_q;

  // stage 1
  logic        [63:0]    rmul_q;
  logic signed [50:0]    azmul_q;
  logic signed [TW-1:0]  t1_q;
  logic signed [33:0]    hsum_q;
  // stage 2
  logic signed [33:0]    rad2_q;
  logic signed [35:0]    rdiff2_q;
  logic signed [54:0]    vmul2_q;
  // stage 3
  logic signed [34:0]    raddiff3_q;
  logic signed [56:0]    rotmul3_q;
  logic signed [54:0]    vmul3_q;
  // stage 4
  logic signed [55:0]    radmul4_q;
  logic signed [56:0]    rotmul4_q;
  logic signed [54:0]    vmul4_q;
  // stage 5
  c2jp_pkg::out_item_t   out_q;

  logic [33:0]        xs;
  logic signed [63:0] rot_w, rad_w, ver_w, rot_t, rad_t, ver_t;
  c2jp_pkg::clip_t    rot_c, rad_c, ver_c;

  assign xs = vec_i.cx[c2jp_pkg::GuardBits +: 34];

  // divide toward zero by a power of two
  assign rot_w = 64'(rotmul4_q);
  assign rad_w = 64'(radmul4_q);
  assign ver_w = 64'(vmul4_q);
  assign rot_t = (rot_w + (rot_w[63] ? 64'sh0_ffff_ffff : 64'sd0)) >>> 32;
  assign rad_t = (rad_w + (rad_w[63] ? 64'sd65535 : 64'sd0)) >>> 16;
  assign ver_t = (ver_w + (ver_w[63] ? 64'sd65535 : 64'sd0)) >>> 16;
  assign rot_c = c2jp_pkg::clip32(rot_t);
  assign rad_c = c2jp_pkg::clip32(rad_t);
  assign ver_c = c2jp_pkg::clip32(ver_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rmul_q  <= 64'(xs) * 64'(c2jp_pkg::InvGainQ30);
      azmul_q <= 51'(cfg_i.angle_zero) * 51'($signed({1'b0, c2jp_pkg::InvTwoPiQ32}));
      t1_q    <= vec_i.theta;
      hsum_q  <= 34'(vec_i.z) + 34'(cfg_i.height_offset) - 34'(cfg_i.height_zero);

      rad2_q   <= $signed({1'b0, rmul_q[62:30]});
      rdiff2_q <= 36'(t1_q) - 36'(azmul_q >>> 16);
      vmul2_q  <= 55'(hsum_q) * 55'($signed({1'b0, cfg_i.vertical_resolution}));

      raddiff3_q <= 35'(rad2_q) - 35'(cfg_i.radius_zero);
      rotmul3_q  <= 57'(rdiff2_q) * 57'($signed({1'b0, cfg_i.rotary_resolution}));
      vmul3_q    <= vmul2_q;

      radmul4_q <= 56'(raddiff3_q) * 56'($signed({1'b0, cfg_i.radial_resolution}));
      rotmul4_q <= rotmul3_q;
      vmul4_q   <= vmul3_q;

      out_q.rotary_pulses   <= rot_c.value;
      out_q.radial_pulses   <= rad_c.value;
      out_q.vertical_pulses <= ver_c.value;
      out_q.saturated       <= rot_c.sat | rad_c.sat | ver_c.sat;
    end
  end

  assign valid_o = v_q[4];
  assign item_o  = out_q;

endmodule

/* rtl/cartesian_to_joint_pulses_core.sv */
// Top level: Cartesian target to rotary, radial and vertical joint pulse targets.
// Takes one target per cycle while the result side does not stall. An item passes
// 26 register stages (one entry stage, one stage per CORDIC iteration, five scaling
// stages) before its result is valid. A stall of a valid result freezes the whole
// pipeline, so the input side stalls in the same cycle; nothing is dropped or
// repeated. Configuration writes are always ready and take effect on the next
// item through each stage.
module cartesian_to_joint_pulses_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  c2jp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output c2jp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [c2jp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  logic            en;
  logic            vec_valid;
  c2jp_pkg::vec_t  vec;
  c2jp_pkg::cfg_t  cfg;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  c2jp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  c2jp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (vec_valid),
    .vec_o   (vec)
  );

  c2jp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_valid),
    .vec_i   (vec),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .item_o  (out_data_o)
  );

endmodule

/* tb/sv/cartesian_to_joint_pulses_checker.sv */
// Checker: watches the target, configuration and pulse channels, predicts and compares results.
module cartesian_to_joint_pulses_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  c2jp_pkg::in_item_t    in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  c2jp_pkg::out_item_t   out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [31:0]           cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import c2jp_pkg::*;

  localparam longint TurnTable [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  longint h_off, a_zero, r_zero, h_zero, rot_res, rad_res, ver_res;
  out_item_t pulses_due [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o = pulses_due.size();

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat32(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_item_t joint_pulses(in_item_t t);
    longint x, y, z, theta, radius, cx, cy, nx, ny, azt, rot, rad, ver;
    logic flag;
    out_item_t r;
    x = longint'(t.target_x);
    y = longint'(t.target_y);
    z = longint'(t.target_z);
    theta = 0;
    radius = 0;
    flag = 1'b0;
    if (x != 0 || y != 0) begin
      if (y >= 0) begin
        cx = y;
        cy = x;
      end else begin
        cx = -y;
        cy = -x;
        theta = (x >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      end
      cx = cx * 256;
      cy = cy * 256;
      for (int i = 0; i < CordicSteps && i < 32; i++) begin
        if (cy >= 0) begin
          nx = cx + shr_floor(cy, i);
          ny = cy - shr_floor(cx, i);
          theta += TurnTable[i];
        end else begin
          nx = cx - shr_floor(cy, i);
          ny = cy + shr_floor(cx, i);
          theta -= TurnTable[i];
        end
        cx = nx;
        cy = ny;
      end
      radius = shr_floor(shr_floor(cx, 8) * 64'sd652032874, 30);
    end
    azt = shr_floor(a_zero * 64'sd683565276, 16);
    rot = ((theta - azt) * rot_res) / 64'sd4294967296;
    rad = ((radius - r_zero) * rad_res) / 64'sd65536;
    ver = ((z + h_off - h_zero) * ver_res) / 64'sd65536;
    r.rotary_pulses = 32'(sat32(rot, flag));
    r.radial_pulses = 32'(sat32(rad, flag));
    r.vertical_pulses = 32'(sat32(ver, flag));
    r.saturated = flag;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      h_off <= 0; a_zero <= 0; r_zero <= 0; h_zero <= 0;
      rot_res <= 0; rad_res <= 0; ver_res <= 0;
      fails <= 0;
      pulses_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHeightOffset: h_off <= longint'($signed(cfg_data_i));
          RegAngleZero:    a_zero <= longint'($signed(cfg_data_i[19:0]));
          RegRadiusZero:   r_zero <= longint'($signed(cfg_data_i));
          RegHeightZero:   h_zero <= longint'($signed(cfg_data_i));
          RegRotaryRes:    rot_res <= longint'({1'b0, cfg_data_i[19:0]});
          RegRadialRes:    rad_res <= longint'({1'b0, cfg_data_i[19:0]});
          RegVerticalRes:  ver_res <= longint'({1'b0, cfg_data_i[19:0]});
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) pulses_due.push_back(joint_pulses(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (pulses_due.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", out_data_i);
          fails <= fails + 1;
        end else begin
          want = pulses_due.pop_front();
          if (want !== out_data_i) begin
            if (fails < 10)
              $display("mismatch: exp rot %0d rad %0d ver %0d sat %b, got %0d %0d %0d %b",
                       want.rotary_pulses, want.radial_pulses, want.vertical_pulses,
                       want.saturated, out_data_i.rotary_pulses, out_data_i.radial_pulses,
                       out_data_i.vertical_pulses, out_data_i.saturated);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/sv/cartesian_to_joint_pulses_core_test.sv */
// Testbench top: drives targets and register writes, idles both sides, gives the verdict.
module cartesian_to_joint_pulses_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import c2jp_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [31:0] cfg_index, cfg_data;
  int fail_count, pending;
  int in_idle_pct, out_idle_pct;
  bit hold_off;

  cartesian_to_joint_pulses_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  cartesian_to_joint_pulses_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stall, with an optional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_target(input logic [31:0] x, y, z);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{target_x: x, target_y: y, target_z: z};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic random_config(input int mode);
    logic [31:0] v [7];
    for (int i = 0; i < 7; i++) v[i] = $urandom;
    if (mode == 0) begin
      v[1] = $urandom_range(1) ? 32'd411775 : -32'sd411775;
      v[4] = 32'hfffff; v[5] = 32'hfffff; v[6] = 32'hfffff;
    end else if (mode == 1) begin
      v[1] = $signed($urandom_range(823550)) - 411775;
      v[4] = $urandom_range(4096); v[5] = $urandom_range(4096);
      v[6] = $urandom_range(4096);
    end
    for (int i = 0; i < 7; i++) write_reg(cfg_reg_e'(i), v[i]);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_off = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // reset config: everything zero
    send_target(32'h00010000, 32'h00010000, 32'h00010000);
    drain();
    write_reg(RegHeightOffset, 32'h00008000);
    write_reg(RegAngleZero, 32'h00001000);
    write_reg(RegRadiusZero, 32'hffff0000);
    write_reg(RegHeightZero, 32'h00004000);
    write_reg(RegRotaryRes, 32'hfff00400);
    write_reg(RegRadialRes, 32'd2000);
    write_reg(RegVerticalRes, 32'd1000);
    cfg_index <= 32'd7;
    write_reg(cfg_reg_e'(7), 32'h12345678);
    // directed: origin, axes, negative y both signs of x, extremes
    send_target(0, 0, 0);
    send_target(32'h00010000, 0, 32'h7fffffff);
    send_target(32'hffff0000, 0, 32'h80000000);
    send_target(0, 32'h00010000, 0);
    send_target(0, 32'hffff0000, 0);
    send_target(32'h00010000, 32'hffff0000, 0);
    send_target(32'hffff0000, 32'hffff0000, 0);
    send_target(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_target(32'h80000000, 32'h80000000, 32'h80000000);
    send_target(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_target(32'h80000000, 32'h7fffffff, 1);
    send_target(1, 32'hffffffff, 32'hffffffff);
    send_target(32'hffffffff, 1, 0);
    drain();
    random_config(0);
    send_target(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_target(32'h80000000, 32'hffffffff, 32'h80000000);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 70 : 0;
      out_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 26 : 0;
      for (int s = 0; s < 5; s++) begin
        random_config(s % 3);
        if (phase == 2 && s == 1) hold_off = 1'b1;
        repeat (50) send_target(rand_coord(), rand_coord(), rand_coord());
        drain();
      end
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/c2jp_pkg.sv
rtl/c2jp_cfg.sv
rtl/c2jp_cordic.sv
rtl/c2jp_scale.sv
rtl/cartesian_to_joint_pulses_core.sv
tb/sv/cartesian_to_joint_pulses_checker.sv
tb/sv/cartesian_to_joint_pulses_core_test.sv
